// ----- sv/vna_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package vna_pkg;
    localparam int MaxVertices = 1024;
    localparam int IdxBits     = $clog2(MaxVertices);
    localparam int CntBits     = IdxBits + 1;
    localparam int CoordBits   = 20;
    localparam int AccBits     = 56;

    localparam logic [1:0] KIND_STORE = 2'd0;
    localparam logic [1:0] KIND_FACE  = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_BADIDX = 2'd2;
    localparam logic [1:0] ST_RANGE  = 2'd3;

    localparam logic signed [AccBits-1:0] AccMax = {1'b0, {(AccBits-1){1'b1}}};
    localparam logic signed [AccBits-1:0] AccMin = {1'b1, {(AccBits-1){1'b0}}};
endpackage
`default_nettype wire

// ----- sv/vna_divider.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per cycle: 46-bit dividend, 32-bit divisor.
module vna_divider
    import vna_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        go,
    input  wire logic [45:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [45:0]      quotient
);
    logic [45:0] q_reg;
    logic [31:0] r_reg;
    logic [31:0] d_reg;
    logic [5:0]  n_reg;
    logic        run_reg;
    logic [32:0] trial;
    logic [33:0] diff;

    always_comb
    begin
        trial = {r_reg, q_reg[45]};
        diff  = {1'b0, trial} - {2'b00, d_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            n_reg   <= '0;
        end
        else if (go)
        begin
            run_reg <= 1'b1;
            n_reg   <= 6'd46;
        end
        else if (run_reg)
        begin
            n_reg <= n_reg - 6'd1;
            if (n_reg == 6'd1)
                run_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (run_reg)
        begin
            if (!diff[33])
            begin
                r_reg <= diff[31:0];
                q_reg <= {q_reg[44:0], 1'b1};
            end
            else
            begin
                r_reg <= trial[31:0];
                q_reg <= {q_reg[44:0], 1'b0};
            end
        end
    end

    assign done     = run_reg && (n_reg == 6'd1);
    assign quotient = diff[33] ? {q_reg[44:0], 1'b0} : {q_reg[44:0], 1'b1};
endmodule
`default_nettype wire

// ----- sv/vertex_normal_accumulator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Strobe after acceptance: store, skipped face, bad query or unused kind go straight to
// S_DONE; a face reads 3 vertices, forms 6 products, makes 3 read-add-write passes; a query with a
// zero accumulator ends after scaling, else scaling steps, 3 squares, 32 root steps, 3 divisions.
// busy holds from acceptance through the strobe; the next beat can be taken in the cycle after it.
// The receiver cannot stall: result is valid for the single cycle of done.
// Reset clears vertex count and control; storing a vertex clears its accumulator.
module vertex_normal_accumulator
    import vna_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         kind,
    input  wire logic signed [19:0] coord_x,
    input  wire logic signed [19:0] coord_y,
    input  wire logic signed [19:0] coord_z,
    input  wire logic signed [11:0] corner_a,
    input  wire logic signed [11:0] corner_b,
    input  wire logic signed [11:0] corner_c,
    input  wire logic [10:0]        query_vertex,
    output logic                    done,
    output logic [1:0]              status,
    output logic signed [15:0]      normal_x,
    output logic signed [15:0]      normal_y,
    output logic signed [15:0]      normal_z
);
    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_VRD   = 14'b00000000000010, // read one corner vertex
        S_VWT   = 14'b00000000000100, // latch corner vertex
        S_MUL   = 14'b00000000001000, // six products, one per cycle
        S_ARD   = 14'b00000000010000, // read accumulator of a corner
        S_AWT   = 14'b00000000100000,
        S_AWR   = 14'b00000001000000, // saturating add, write back
        S_QWT   = 14'b00000010000000,
        S_SCALE = 14'b00000100000000, // normalising shift, one bit a step
        S_SQ    = 14'b00001000000000, // squares, one per cycle
        S_SQRT  = 14'b00010000000000,
        S_DIV   = 14'b00100000000000,
        S_DWAIT = 14'b01000000000000,
        S_DONE  = 14'b10000000000000
    } state_t;

    state_t state_reg;
    logic [CntBits-1:0] count_reg;
    logic [1:0] kind_q;

    // vertex store: undefined until written
    logic [3*CoordBits-1:0] vmem [MaxVertices];
    logic [3*CoordBits-1:0] vrd_reg;
    // accumulators, cleared when their vertex is stored
    logic [3*AccBits-1:0]   amem [MaxVertices];
    logic [3*AccBits-1:0]   ard_reg;

    logic [IdxBits-1:0] idx_reg [3];
    logic [1:0]         sel_reg;
    logic signed [CoordBits-1:0] px_reg [3];
    logic signed [CoordBits-1:0] py_reg [3];
    logic signed [CoordBits-1:0] pz_reg [3];
    logic [2:0]   step_reg;
    logic signed [43:0] prod_reg;
    logic signed [AccBits-1:0] n_reg [3];
    logic [1:0]  status_reg;
    logic signed [15:0] out_reg [3];

    // query datapath
    logic [55:0] mag_reg [3];
    logic        neg_reg [3];
    logic [63:0] sum_reg;
    logic [63:0] rem_reg;
    logic [31:0] root_reg;
    logic [5:0]  cnt_reg;

    // corner resolution
    function automatic logic [CntBits:0] resolve(input logic signed [11:0] f,
                                                  input logic [CntBits-1:0] cnt);
        logic signed [CntBits+1:0] r;
        logic ok;
        begin
            r  = (f < 0) ? (CntBits+2)'($signed({2'b00, cnt}) + (CntBits+2)'(f) + 1)
                         : (CntBits+2)'(f);
            ok = (r >= 1) && (r <= $signed({2'b00, cnt}));
            resolve = {ok, CntBits'(r - 1)};
        end
    endfunction

    logic [CntBits:0] ra, rb, rc;
    assign ra = resolve(corner_a, count_reg);
    assign rb = resolve(corner_b, count_reg);
    assign rc = resolve(corner_c, count_reg);

    // one multiplier shared by the six cross-product terms: 21x21 signed
    logic signed [20:0] ma, mb;
    logic signed [41:0] mprod;
    logic signed [20:0] ux, uy, uz, wx, wy, wz;
    assign ux = 21'(px_reg[1]) - 21'(px_reg[0]);
    assign uy = 21'(py_reg[1]) - 21'(py_reg[0]);
    assign uz = 21'(pz_reg[1]) - 21'(pz_reg[0]);
    assign wx = 21'(px_reg[2]) - 21'(px_reg[0]);
    assign wy = 21'(py_reg[2]) - 21'(py_reg[0]);
    assign wz = 21'(pz_reg[2]) - 21'(pz_reg[0]);
    always_comb
    begin
        case (step_reg)
            3'd0:    begin ma = uy; mb = wz; end
            3'd1:    begin ma = uz; mb = wy; end
            3'd2:    begin ma = uz; mb = wx; end
            3'd3:    begin ma = ux; mb = wz; end
            3'd4:    begin ma = ux; mb = wy; end
            default: begin ma = uy; mb = wx; end
        endcase
    end
    assign mprod = ma * mb;

    // unsigned square of a 31-bit magnitude
    logic [31:0] sqa;
    logic [63:0] sqp;
    assign sqa = mag_reg[sel_reg][31:0];
    assign sqp = sqa * sqa;

    function automatic logic signed [AccBits-1:0] sat_add(
        input logic signed [AccBits-1:0] a, input logic signed [AccBits-1:0] b);
        logic signed [AccBits:0] s;
        begin
            s = {a[AccBits-1], a} + {b[AccBits-1], b};
            if (s > $signed({1'b0, AccMax}))      sat_add = AccMax;
            else if (s < $signed({1'b1, AccMin})) sat_add = AccMin;
            else                                   sat_add = s[AccBits-1:0];
        end
    endfunction

    logic [3*AccBits-1:0] acur, anew;
    assign acur = ard_reg;
    assign anew = {sat_add(acur[3*AccBits-1:2*AccBits], n_reg[0]),
                   sat_add(acur[2*AccBits-1:AccBits], n_reg[1]),
                   sat_add(acur[AccBits-1:0], n_reg[2])};

    // square root step (bit pair per cycle)
    logic [33:0] sq_trial;
    logic [63:0] rem_sh;
    assign rem_sh   = {rem_reg[61:0], sum_reg[63:62]};
    assign sq_trial = {rem_sh[33:0]} - {root_reg, 2'b01};

    // divider
    logic        div_go, div_done;
    logic [45:0] div_q;
    logic [45:0] div_n;
    assign div_n = {mag_reg[sel_reg][31:0], 14'd0} + 46'(root_reg >> 1);
    vna_divider u_div (
        .clk(clk), .rst_n(rst_n), .go(div_go),
        .dividend(div_n), .divisor(root_reg),
        .done(div_done), .quotient(div_q)
    );
    assign div_go = (state_reg == S_DIV);

    logic [55:0] mmax;
    assign mmax = mag_reg[0] | mag_reg[1] | mag_reg[2];

    function automatic logic [55:0] absv(input logic signed [AccBits-1:0] v);
        absv = v[AccBits-1] ? 56'(-v) : 56'(v);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            status_reg <= ST_OK;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                    if (start)
                    begin
                        status_reg <= ST_OK;
                        case (kind)
                            KIND_STORE:
                            begin
                                if (count_reg == CntBits'(MaxVertices))
                                    status_reg <= ST_FULL;
                                else
                                    count_reg <= count_reg + 1'b1;
                                state_reg <= S_DONE;
                            end
                            KIND_FACE:
                                if (ra[CntBits] && rb[CntBits] && rc[CntBits])
                                    state_reg <= S_VRD;
                                else
                                begin
                                    status_reg <= ST_BADIDX;
                                    state_reg  <= S_DONE;
                                end
                            KIND_QUERY:
                                if (query_vertex == 11'd0 ||
                                    CntBits'(query_vertex) > count_reg)
                                begin
                                    status_reg <= ST_RANGE;
                                    state_reg  <= S_DONE;
                                end
                                else
                                    state_reg <= S_ARD;
                            default: state_reg <= S_DONE;
                        endcase
                    end
                S_VRD: state_reg <= S_VWT;
                S_VWT: state_reg <= (sel_reg == 2'd2) ? S_MUL : S_VRD;
                S_MUL: if (step_reg == 3'd6) state_reg <= S_ARD;
                S_ARD: state_reg <= (kind_q == KIND_QUERY) ? S_QWT : S_AWT;
                S_AWT: state_reg <= S_AWR;
                S_AWR: state_reg <= (sel_reg == 2'd2) ? S_DONE : S_ARD;
                S_QWT: state_reg <= S_SCALE;
                S_SCALE:
                    if (mmax == 56'd0)
                        state_reg <= S_DONE;
                    else if (mmax[55:31] == 25'd0 && mmax[30])
                        state_reg <= S_SQ;
                S_SQ: if (sel_reg == 2'd2) state_reg <= S_SQRT;
                S_SQRT: if (cnt_reg == 6'd31) state_reg <= S_DIV;
                S_DIV: state_reg <= S_DWAIT;
                S_DWAIT:
                    if (div_done)
                        state_reg <= (sel_reg == 2'd2) ? S_DONE : S_DIV;
                S_DONE: state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
                if (start)
                begin
                    kind_q     <= kind;
                    sel_reg    <= 2'd0;
                    step_reg   <= 3'd0;
                    out_reg[0] <= '0;
                    out_reg[1] <= '0;
                    out_reg[2] <= '0;
                    idx_reg[0] <= (kind == KIND_QUERY) ? IdxBits'(query_vertex - 11'd1)
                                                       : ra[IdxBits-1:0];
                    idx_reg[1] <= rb[IdxBits-1:0];
                    idx_reg[2] <= rc[IdxBits-1:0];
                    // a new vertex starts from a zero accumulator
                    if (kind == KIND_STORE && count_reg != CntBits'(MaxVertices))
                    begin
                        vmem[count_reg[IdxBits-1:0]] <=
                            {coord_x, coord_y, coord_z};
                        amem[count_reg[IdxBits-1:0]] <= '0;
                    end
                end
            S_VRD: vrd_reg <= vmem[idx_reg[sel_reg]];
            S_VWT:
            begin
                px_reg[sel_reg] <= vrd_reg[59:40];
                py_reg[sel_reg] <= vrd_reg[39:20];
                pz_reg[sel_reg] <= vrd_reg[19:0];
                sel_reg <= (sel_reg == 2'd2) ? 2'd0 : sel_reg + 2'd1;
            end
            S_MUL:
            begin
                // products are registered and used in the next step; odd steps form the difference
                prod_reg <= 44'(mprod);
                step_reg <= step_reg + 3'd1;
                if (step_reg == 3'd1) n_reg[0] <= AccBits'(prod_reg) - AccBits'(mprod);
                if (step_reg == 3'd3) n_reg[1] <= AccBits'(prod_reg) - AccBits'(mprod);
                if (step_reg == 3'd5) n_reg[2] <= AccBits'(prod_reg) - AccBits'(mprod);
            end
            S_ARD:
                ard_reg <= amem[idx_reg[sel_reg]];
            S_AWR:
            begin
                amem[idx_reg[sel_reg]] <= anew;
                sel_reg <= sel_reg + 2'd1;
            end
            S_QWT:
            begin
                mag_reg[0] <= absv(acur[3*AccBits-1:2*AccBits]);
                mag_reg[1] <= absv(acur[2*AccBits-1:AccBits]);
                mag_reg[2] <= absv(acur[AccBits-1:0]);
                neg_reg[0] <= acur[3*AccBits-1];
                neg_reg[1] <= acur[2*AccBits-1];
                neg_reg[2] <= acur[AccBits-1];
                sum_reg    <= '0;
            end
            S_SCALE:
                if (mmax[55:31] != 25'd0)
                begin
                    mag_reg[0] <= mag_reg[0] >> 1;
                    mag_reg[1] <= mag_reg[1] >> 1;
                    mag_reg[2] <= mag_reg[2] >> 1;
                end
                else if (!mmax[30] && mmax != 56'd0)
                begin
                    mag_reg[0] <= mag_reg[0] << 1;
                    mag_reg[1] <= mag_reg[1] << 1;
                    mag_reg[2] <= mag_reg[2] << 1;
                end
            S_SQ:
            begin
                sum_reg  <= sum_reg + sqp;
                sel_reg  <= (sel_reg == 2'd2) ? 2'd0 : sel_reg + 2'd1;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= '0;
            end
            S_SQRT:
            begin
                sum_reg <= {sum_reg[61:0], 2'b00};
                cnt_reg <= cnt_reg + 6'd1;
                if (rem_sh[63:34] == 30'd0 && !sq_trial[33] ||
                    rem_sh[63:34] != 30'd0)
                begin
                    rem_reg  <= rem_sh - {30'd0, root_reg, 2'b01};
                    root_reg <= {root_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[30:0], 1'b0};
                end
            end
            S_DWAIT:
                if (div_done)
                begin
                    out_reg[sel_reg] <= neg_reg[sel_reg] ? 16'(-div_q) : 16'(div_q);
                    sel_reg <= sel_reg + 2'd1;
                end
            default: ;
        endcase
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = (state_reg == S_DONE);
    assign status   = status_reg;
    assign normal_x = done ? out_reg[0] : '0;
    assign normal_y = done ? out_reg[1] : '0;
    assign normal_z = done ? out_reg[2] : '0;
endmodule
`default_nettype wire
